// ===== hw/rtl/glim_pkg.sv =====
`default_nettype none
package glim_pkg;

  localparam int ExtCapacity = 1024;
  localparam int HashSlots   = 2048;
  localparam int IdxW        = 31;
  localparam int SlotW       = $clog2(HashSlots);
  localparam int PosW        = $clog2(ExtCapacity);
  localparam int CntW        = $clog2(ExtCapacity + 1);
  localparam int ProbeW      = $clog2(HashSlots + 1);
  localparam int KeyW        = IdxW;
  localparam int SlotDataW   = KeyW + PosW;
  localparam logic [31:0] HashMult = 32'd2654435761;

  typedef enum logic [2:0] {
    ST_OWNED    = 3'd0,
    ST_FOUND    = 3'd1,
    ST_INSERTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_UNUSED   = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CMD_G2L = 1'b0,
    CMD_L2G = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_FIRST = 1'b0,
    REG_LAST  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_CHECK,
    S_L2G_RD,
    S_L2G_OUT,
    S_CLEAR
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;       // capture the incoming item
    logic hash;        // register the home slot
    logic probe_rd;    // read slot at probe pointer
    logic probe_next;  // advance probe pointer
    logic insert;      // write slot, external list, bump count
    logic ext_rd;      // read external list
    logic clr_step;    // clear one valid bit
    logic emit;        // register a result for the output
    status_t status;
    logic [1:0] sel;   // result source
  } glim_cmd_t;

  localparam logic [1:0] SEL_OWNED_G2L = 2'd0;
  localparam logic [1:0] SEL_SLOT      = 2'd1;
  localparam logic [1:0] SEL_EXT       = 2'd2;
  localparam logic [1:0] SEL_ZERO      = 2'd3;

  // datapath -> controller
  typedef struct packed {
    logic is_l2g;
    logic g2l_owned;
    logic l2g_owned;
    logic l2g_ext;
    logic slot_valid;
    logic key_match;
    logic probes_done;
    logic ext_full;
    logic clr_done;
  } glim_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/glim_ram.sv =====
`default_nettype none
module glim_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/glim_ctrl.sv =====
`default_nettype none
module glim_ctrl import glim_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire glim_stat_t stat,
  output glim_cmd_t       cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (stat.clr_done) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_HASH;
      S_HASH: begin
        if (stat.is_l2g) begin
          state_nxt = (stat.l2g_owned || !stat.l2g_ext) ? S_IDLE : S_L2G_RD;
        end else if (stat.g2l_owned) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE:  state_nxt = S_CHECK;
      S_CHECK: begin
        if (!stat.slot_valid || stat.key_match || stat.probes_done) state_nxt = S_IDLE;
        else state_nxt = S_PROBE;
      end
      S_L2G_RD:  state_nxt = S_L2G_OUT;
      S_L2G_OUT: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = ST_OWNED;
    cmd.sel = SEL_ZERO;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE:  cmd.latch = start;
      S_HASH: begin
        cmd.hash = 1'b1;
        if (stat.is_l2g) begin
          if (stat.l2g_owned) begin
            cmd.emit = 1'b1; cmd.status = ST_OWNED; cmd.sel = SEL_OWNED_G2L;
          end else if (!stat.l2g_ext) begin
            cmd.emit = 1'b1; cmd.status = ST_UNUSED; cmd.sel = SEL_ZERO;
          end
        end else if (stat.g2l_owned) begin
          cmd.emit = 1'b1; cmd.status = ST_OWNED; cmd.sel = SEL_OWNED_G2L;
        end
      end
      S_PROBE: cmd.probe_rd = 1'b1;
      S_CHECK: begin
        if (stat.slot_valid && stat.key_match) begin
          cmd.emit = 1'b1; cmd.status = ST_FOUND; cmd.sel = SEL_SLOT;
        end else if (stat.slot_valid && !stat.probes_done) begin
          cmd.probe_next = 1'b1;
        end else if (stat.slot_valid || stat.ext_full) begin
          cmd.emit = 1'b1; cmd.status = ST_FULL; cmd.sel = SEL_ZERO;
        end else begin
          cmd.insert = 1'b1;
          cmd.emit = 1'b1; cmd.status = ST_INSERTED; cmd.sel = SEL_SLOT;
        end
      end
      S_L2G_RD:  cmd.ext_rd = 1'b1;
      S_L2G_OUT: begin
        cmd.emit = 1'b1; cmd.status = ST_FOUND; cmd.sel = SEL_EXT;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/glim_dp.sv =====
`default_nettype none
module glim_dp import glim_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic            cfg_sel,
  input  wire logic [IdxW-1:0] cfg_data,
  input  wire logic            in_cmd,
  input  wire logic [IdxW-1:0] in_index_in,
  input  wire logic            in_batch_end,
  input  wire glim_cmd_t       cmd,
  output glim_stat_t           stat,
  output logic                 out_valid,
  output logic [IdxW-1:0]      out_index_out,
  output logic [2:0]           out_status,
  output logic                 out_batch_end_out
);
  logic [IdxW-1:0] first_r, last_r;
  logic            cmd_r, be_r;
  logic [IdxW-1:0] idx_r;
  logic [IdxW:0]   nloc_r;
  logic [SlotW-1:0] ptr_r, ptr_nxt;
  logic [ProbeW-1:0] nprobe_r;
  logic [CntW-1:0] count_r;
  logic [SlotW-1:0] clr_r;
  logic clr_done_r;
  logic [SlotDataW:0] slot_rd;
  logic [IdxW-1:0] ext_rd;
  logic [PosW-1:0] ext_addr;
  logic [31:0] hprod;
  logic [IdxW:0] pdiff;

  // owned count, up to 2^31; empty range gives zero
  logic [IdxW:0] nloc;
  assign nloc = (last_r < first_r) ? '0
              : ({1'b0, last_r} - {1'b0, first_r} + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      last_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_sel == REG_FIRST) first_r <= cfg_data;
      else                      last_r  <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_cmd;
      idx_r  <= in_index_in;
      be_r   <= in_batch_end;
      nloc_r <= nloc;
    end
  end

  assign hprod = {1'b0, idx_r} * HashMult;
  assign ptr_nxt = ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      ptr_r    <= hprod[SlotW-1:0];
      nprobe_r <= '0;
    end else if (cmd.probe_next) begin
      ptr_r    <= ptr_nxt;
      nprobe_r <= nprobe_r + 1'b1;
    end
  end

  // valid bit lives in the slot RAM; a pass after reset writes every slot empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == SlotW'(HashSlots - 1)) clr_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cmd.insert) count_r <= count_r + 1'b1;
  end

  glim_ram #(.Width(SlotDataW + 1), .Depth(HashSlots)) u_slots (
    .clk(clk), .we(cmd.insert || cmd.clr_step),
    .waddr(cmd.clr_step ? clr_r : ptr_r),
    .wdata(cmd.clr_step ? '0 : {1'b1, idx_r, count_r[PosW-1:0]}),
    .raddr(ptr_r), .rdata(slot_rd)
  );

  assign pdiff = {1'b0, idx_r} - nloc_r;
  assign ext_addr = cmd.insert ? count_r[PosW-1:0] : pdiff[PosW-1:0];

  glim_ram #(.Width(IdxW), .Depth(ExtCapacity)) u_ext (
    .clk(clk), .we(cmd.insert), .waddr(count_r[PosW-1:0]), .wdata(idx_r),
    .raddr(ext_addr), .rdata(ext_rd)
  );

  assign stat.is_l2g      = (cmd_r == CMD_L2G);
  assign stat.g2l_owned   = (nloc_r != '0) && (idx_r >= first_r) && (idx_r <= last_r);
  assign stat.l2g_owned   = ({1'b0, idx_r} < nloc_r);
  assign stat.l2g_ext     = !pdiff[IdxW] && (pdiff[IdxW-1:0] < IdxW'(count_r));
  assign stat.slot_valid  = slot_rd[SlotDataW];
  assign stat.key_match   = (slot_rd[SlotDataW-1:PosW] == idx_r);
  assign stat.probes_done = (nprobe_r == ProbeW'(HashSlots - 1));
  assign stat.ext_full    = (count_r == CntW'(ExtCapacity));
  assign stat.clr_done    = clr_done_r;

  logic [IdxW-1:0] res;
  always_comb begin
    case (cmd.sel)
      SEL_OWNED_G2L: res = stat.is_l2g ? (first_r + idx_r) : (idx_r - first_r);
      SEL_SLOT: res = nloc_r[IdxW-1:0] + (cmd.insert ? IdxW'(count_r[PosW-1:0])
                                                     : IdxW'(slot_rd[PosW-1:0]));
      SEL_EXT:  res = ext_rd;
      default:  res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= cmd.emit;
    if (cmd.emit) begin
      out_index_out     <= res;
      out_status        <= cmd.status;
      out_batch_end_out <= be_r;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/global_local_index_map_top.sv =====
`default_nettype none
// channel | ports                                   | handshake
// input   | start, busy, in_cmd/index_in/batch_end  | start && !busy
// result  | out_valid, out_index_out/status/be_out  | one-cycle strobe
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
// Owned/unused requests resolve in S_HASH; external reads add S_L2G_RD
// and S_L2G_OUT. Hash lookup: S_PROBE (registered RAM read), S_CHECK.
// After reset a pass clears the slot valid bits; busy stays high.
// Results cannot be stalled; busy holds off the next item until done.
module global_local_index_map_top import glim_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            in_cmd,
  input  wire logic [IdxW-1:0] in_index_in,
  input  wire logic            in_batch_end,
  output logic                 out_valid,
  output logic [IdxW-1:0]      out_index_out,
  output logic [2:0]           out_status,
  output logic                 out_batch_end_out,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_index,
  input  wire logic [IdxW-1:0] cfg_data
);
  glim_cmd_t  cmd;
  glim_stat_t stat;
  logic       busy_c;

  assign cfg_ready = 1'b1;
  assign busy = busy_c || out_valid;

  glim_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start && !busy),
    .busy(busy_c), .stat(stat), .cmd(cmd)
  );

  glim_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_valid && cfg_ready), .cfg_sel(cfg_index), .cfg_data(cfg_data),
    .in_cmd(in_cmd), .in_index_in(in_index_in), .in_batch_end(in_batch_end),
    .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_index_out(out_index_out),
    .out_status(out_status), .out_batch_end_out(out_batch_end_out)
  );

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back results");
  a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_UNUSED))
      |-> (out_index_out == '0)) else $error("error result not zero");
  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.insert, cmd.clr_step, cmd.latch})) else $error("cmd clash");
endmodule
`default_nettype wire
